// ===== sv/msoc_pkg.sv =====
// Shared types, constants and helper functions of the motor state observer controller.
package msoc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QW        = 32;
  localparam int MW        = QW + 1;
  localparam int PW        = 2 * MW;
  localparam int ACC_W     = PW + 2;
  localparam int CMD_W     = 16;
  localparam int CNT_W     = 16;
  localparam int DW        = CNT_W + 1;
  localparam int CFG_IW    = 3;
  localparam int CFG_DW    = 64;
  localparam int IN_DW     = 56;
  localparam int OUT_DW    = 80;

  localparam logic signed [DW-1:0] COUNT_WRAP = DW'(65535);

  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [MW-1:0] Q_ONE =
    {{(MW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [CFG_IW-1:0] {
    REG_HIL_MODE,
    REG_PLANT_F,
    REG_PLANT_G,
    REG_FEEDBACK_K,
    REG_OBSERVER_L,
    REG_REF_GAIN,
    REG_COUNT_GAIN,
    REG_INV_PERIOD
  } cfg_reg_e;

  typedef enum logic [2:0] {
    DST_N0,
    DST_N1,
    DST_MEAS,
    DST_CMD,
    DST_HIL
  } dst_e;

  typedef struct packed {
    logic valid;
    logic shift;
    logic first;
    logic seed;
    logic last;
    dst_e dst;
  } mac_op_t;

  typedef struct packed {
    logic valid;
    dst_e dst;
  } mac_res_t;

  // Sign-extends a Q value to the multiplier operand width.
  function automatic logic signed [MW-1:0] sext_m(input logic signed [QW-1:0] v);
    return {v[QW-1], v};
  endfunction

  // Saturates a wide accumulator value to the signed Q range.
  function automatic logic signed [QW-1:0] sat_q(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] lim_hi;
    logic signed [ACC_W-1:0] lim_lo;
    lim_hi = {{(ACC_W-QW){1'b0}}, Q_MAX};
    lim_lo = {{(ACC_W-QW){1'b1}}, Q_MIN};
    if (x > lim_hi) begin
      return Q_MAX;
    end else if (x < lim_lo) begin
      return Q_MIN;
    end
    return x[QW-1:0];
  endfunction

endpackage

// ===== sv/motor_state_observer_controller.sv =====
// A normal word runs twelve products through one shared multiplier, a HIL word uses the
// multiplier for its speed estimate, and a start word seeds the state without it.
// The input is not ready while a word is worked on.
// A finished word waits in the output register, so the next word can be taken meanwhile.
// Reset (rst_ni low, asynchronous) clears the observer state, the configuration and all valids.
module motor_state_observer_controller (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata from bit 0: encoder_count[15:0], count_up[16], reference[48:17], zero pad.
  input  logic [msoc_pkg::IN_DW-1:0]         s_axis_tdata,
  // tuser: start_req.
  input  logic                               s_axis_tuser,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata from bit 0: command[15:0], position[47:16], speed[79:48].
  output logic [msoc_pkg::OUT_DW-1:0]        m_axis_tdata,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [msoc_pkg::CFG_IW-1:0]        cfg_index_i,
  input  logic [msoc_pkg::CFG_DW-1:0]        cfg_data_i
);
  import msoc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_e;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_HIL,
    KIND_NORMAL
  } kind_e;

  // One step per product; observer rows, position update, then the command sum.
  typedef enum logic [3:0] {
    ST_N0_EP,
    ST_N0_ES,
    ST_N0_PC,
    ST_N0_MP,
    ST_N1_EP,
    ST_N1_ES,
    ST_N1_PC,
    ST_N1_MP,
    ST_MEAS,
    ST_CMD_REF,
    ST_CMD_N0,
    ST_CMD_N1
  } step_e;

  localparam logic signed [QW-1:0] CMD_HI = QW'(2 ** (CMD_W - 1) - 1);
  localparam logic signed [QW-1:0] CMD_LO = -CMD_HI - QW'(1);

  // Integer part of a Q command, truncated toward zero and clamped to the command range.
  function automatic logic signed [CMD_W-1:0] cmd_of(input logic signed [QW-1:0] c);
    logic signed [QW-1:0] ip;
    ip = c >>> FRAC_BITS;
    if (c[QW-1] && (c[FRAC_BITS-1:0] != '0)) begin
      ip = ip + {{(QW-1){1'b0}}, 1'b1};
    end
    if (ip > CMD_HI) begin
      ip = CMD_HI;
    end else if (ip < CMD_LO) begin
      ip = CMD_LO;
    end
    return ip[CMD_W-1:0];
  endfunction

  // Configuration registers.
  logic                    hil_q;
  logic [CFG_DW-1:0]       plant_f_q;
  logic [CFG_DW-1:0]       plant_g_q;
  logic [CFG_DW-1:0]       feedback_k_q;
  logic [CFG_DW-1:0]       observer_l_q;
  logic signed [QW-1:0]    ref_gain_q;
  logic signed [QW-1:0]    count_gain_q;
  logic signed [QW-1:0]    inv_period_q;

  // Observer and controller state.
  logic signed [QW-1:0]    est_pos_q;
  logic signed [QW-1:0]    est_spd_q;
  logic signed [QW-1:0]    prev_cmd_q;
  logic signed [QW-1:0]    meas_q;
  logic [CNT_W-1:0]        prev_count_q;
  logic signed [QW-1:0]    n0_q;

  // Latched input word and sequencer.
  logic [CNT_W-1:0]        count_q;
  logic                    up_q;
  logic signed [QW-1:0]    ref_q;
  state_e                  state_q;
  kind_e                   kind_q;
  step_e                   step_q;

  logic                    m_valid_q;
  logic [OUT_DW-1:0]       m_data_q;

  logic signed [DW-1:0]    delta_raw;
  logic signed [DW-1:0]    delta;
  mac_op_t                 op;
  logic signed [MW-1:0]    op_a;
  logic signed [MW-1:0]    op_b;
  mac_res_t                res;
  logic signed [QW-1:0]    res_value;
  logic                    in_fire;
  logic signed [CMD_W-1:0] cmd_out;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Count delta, wrapped by the counter period in the counting direction.
  always_comb begin
    delta_raw = $signed({1'b0, count_q}) - $signed({1'b0, prev_count_q});
    delta     = delta_raw;
    if (up_q && delta_raw < 0) begin
      delta = delta_raw + COUNT_WRAP;
    end else if (!up_q && delta_raw > 0) begin
      delta = delta_raw - COUNT_WRAP;
    end
  end

  // Operand selection for the shared multiplier. Both observer rows read the old
  // estimate; the new position estimate waits in n0_q until the command is done.
  always_comb begin
    op       = '0;
    op_a     = '0;
    op_b     = '0;
    if (state_q == S_RUN) begin
      op.valid = 1'b1;
      op.shift = 1'b1;
      if (kind_q == KIND_HIL) begin
        op_a     = sext_m(ref_q) - sext_m(meas_q);
        op_b     = sext_m(inv_period_q);
        op.first = 1'b1;
        op.last  = 1'b1;
        op.dst   = DST_HIL;
      end else begin
        case (step_q)
          ST_N0_EP: begin
            op_a     = Q_ONE - sext_m(observer_l_q[63:32]);
            op_b     = sext_m(est_pos_q);
            op.first = 1'b1;
          end
          ST_N0_ES: begin
            op_a = sext_m(plant_f_q[63:32]);
            op_b = sext_m(est_spd_q);
          end
          ST_N0_PC: begin
            op_a = sext_m(plant_g_q[63:32]);
            op_b = sext_m(prev_cmd_q);
          end
          ST_N0_MP: begin
            op_a    = sext_m(observer_l_q[63:32]);
            op_b    = sext_m(meas_q);
            op.last = 1'b1;
            op.dst  = DST_N0;
          end
          ST_N1_EP: begin
            op_a     = -sext_m(observer_l_q[31:0]);
            op_b     = sext_m(est_pos_q);
            op.first = 1'b1;
          end
          ST_N1_ES: begin
            op_a = sext_m(plant_f_q[31:0]);
            op_b = sext_m(est_spd_q);
          end
          ST_N1_PC: begin
            op_a = sext_m(plant_g_q[31:0]);
            op_b = sext_m(prev_cmd_q);
          end
          ST_N1_MP: begin
            op_a    = sext_m(observer_l_q[31:0]);
            op_b    = sext_m(meas_q);
            op.last = 1'b1;
            op.dst  = DST_N1;
          end
          ST_MEAS: begin
            // Integer product added onto the old measured position.
            op_a     = sext_m(count_gain_q);
            op_b     = MW'(delta);
            op.shift = 1'b0;
            op.first = 1'b1;
            op.seed  = 1'b1;
            op.last  = 1'b1;
            op.dst   = DST_MEAS;
          end
          ST_CMD_REF: begin
            op_a     = sext_m(ref_gain_q);
            op_b     = sext_m(ref_q);
            op.first = 1'b1;
          end
          ST_CMD_N0: begin
            op_a = sext_m(feedback_k_q[63:32]);
            op_b = sext_m(n0_q);
          end
          ST_CMD_N1: begin
            op_a    = sext_m(feedback_k_q[31:0]);
            op_b    = sext_m(est_spd_q);
            op.last = 1'b1;
            op.dst  = DST_CMD;
          end
          default: begin
            op.valid = 1'b0;
          end
        endcase
      end
    end
  end

  msoc_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .a_i         (op_a),
    .b_i         (op_b),
    .seed_i      (meas_q),
    .res_o       (res),
    .res_value_o (res_value)
  );

  assign cmd_out = (kind_q == KIND_NORMAL) ? cmd_of(prev_cmd_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hil_q        <= 1'b0;
      plant_f_q    <= '0;
      plant_g_q    <= '0;
      feedback_k_q <= '0;
      observer_l_q <= '0;
      ref_gain_q   <= '0;
      count_gain_q <= '0;
      inv_period_q <= '0;
      est_pos_q    <= '0;
      est_spd_q    <= '0;
      prev_cmd_q   <= '0;
      meas_q       <= '0;
      prev_count_q <= '0;
      n0_q         <= '0;
      count_q      <= '0;
      up_q         <= 1'b0;
      ref_q        <= '0;
      state_q      <= S_IDLE;
      kind_q       <= KIND_START;
      step_q       <= ST_N0_EP;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_HIL_MODE:   hil_q        <= cfg_data_i[0];
          REG_PLANT_F:    plant_f_q    <= cfg_data_i;
          REG_PLANT_G:    plant_g_q    <= cfg_data_i;
          REG_FEEDBACK_K: feedback_k_q <= cfg_data_i;
          REG_OBSERVER_L: observer_l_q <= cfg_data_i;
          REG_REF_GAIN:   ref_gain_q   <= cfg_data_i[QW-1:0];
          REG_COUNT_GAIN: count_gain_q <= cfg_data_i[QW-1:0];
          REG_INV_PERIOD: inv_period_q <= cfg_data_i[QW-1:0];
          default: begin
          end
        endcase
      end

      // While a finished word is being loaded, the load below decides the valid.
      if (m_valid_q && m_axis_tready && (state_q != S_FINISH)) begin
        m_valid_q <= 1'b0;
      end

      // Results coming back from the shared unit.
      if (res.valid) begin
        case (res.dst)
          DST_N0:   n0_q      <= res_value;
          DST_N1:   est_spd_q <= res_value;
          DST_MEAS: meas_q    <= res_value;
          DST_CMD: begin
            prev_cmd_q   <= res_value;
            est_pos_q    <= n0_q;
            prev_count_q <= count_q;
          end
          DST_HIL: begin
            est_spd_q <= res_value;
            est_pos_q <= ref_q;
            meas_q    <= ref_q;
          end
          default: begin
          end
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            count_q <= s_axis_tdata[15:0];
            up_q    <= s_axis_tdata[16];
            ref_q   <= s_axis_tdata[48:17];
            step_q  <= ST_N0_EP;
            if (s_axis_tuser) begin
              // A start word seeds the state at once.
              kind_q       <= KIND_START;
              prev_cmd_q   <= '0;
              est_pos_q    <= s_axis_tdata[48:17];
              est_spd_q    <= '0;
              meas_q       <= s_axis_tdata[48:17];
              prev_count_q <= s_axis_tdata[15:0];
              state_q      <= S_FINISH;
            end else begin
              kind_q  <= hil_q ? KIND_HIL : KIND_NORMAL;
              state_q <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (kind_q == KIND_HIL || step_q == ST_CMD_N1) begin
            state_q <= S_DRAIN;
          end else begin
            step_q <= step_e'(step_q + 4'd1);
          end
        end
        S_DRAIN: begin
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (!m_valid_q || m_axis_tready) begin
            m_data_q  <= {est_spd_q, meas_q, cmd_out};
            m_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/msoc_mac.sv =====
// Shared multiply-accumulate unit: registered product, exact accumulation, saturated result.
module msoc_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  msoc_pkg::mac_op_t                 op_i,
  input  logic signed [msoc_pkg::MW-1:0]    a_i,
  input  logic signed [msoc_pkg::MW-1:0]    b_i,
  input  logic signed [msoc_pkg::QW-1:0]    seed_i,
  output msoc_pkg::mac_res_t                res_o,
  output logic signed [msoc_pkg::QW-1:0]    res_value_o
);
  import msoc_pkg::*;

  mac_op_t                  op_q;
  logic signed [PW-1:0]     prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= '0;
    end else begin
      op_q <= op_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (op_q.valid) begin
      acc_q <= sum;
    end
  end

  // Q products are floored by the arithmetic shift; the count term is an integer product.
  always_comb begin
    term = op_q.shift ? ACC_W'(prod_q >>> FRAC_BITS) : ACC_W'(prod_q);
    if (op_q.first) begin
      base = op_q.seed ? ACC_W'(seed_i) : '0;
    end else begin
      base = acc_q;
    end
    sum = base + term;
  end

  assign res_o.valid = op_q.valid & op_q.last;
  assign res_o.dst   = op_q.dst;
  assign res_value_o = sat_q(sum);

endmodule
